// ===== hw/rtl/prd_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// prd_pkg
// Shared widths, register codes, lane type and helpers for the pinhole camera
// ray direction pipeline.
// ----------------------------------------------------------------------------
package prd_pkg;

  // component width default
  localparam int CB_DEFAULT   = 16;

  // screen coordinate and view size formats
  localparam int COORD_W      = 17;
  localparam int HALF_COORD   = 32768;
  localparam int SIZE_W       = 16;
  localparam int SIZE_FRAC    = 12;
  localparam int SIZE_RESET   = 8192;
  localparam int DXY_W        = 18;
  localparam int PROD_W       = 35;
  localparam int T_W          = 23;

  // prescaled magnitudes, sum of squares and root
  localparam int MAG_W        = 30;
  localparam int SUM_W        = 2 * MAG_W + 2;
  localparam int SQ_W         = 64;
  localparam int ROOT_W       = 31;
  localparam int SQRT_STEPS   = 32;
  localparam int FRONT_STAGES = 10;

  // configuration port
  localparam int CFG_DATA_W   = 64;
  localparam int CFG_ADDR_W   = 5;
  localparam int VEC_REG_MAX  = 64;

  typedef enum logic [1:0] {
    REG_VIEW  = 2'd0,
    REG_UP    = 2'd1,
    REG_HORIZ = 2'd2,
    REG_SIZE  = 2'd3
  } reg_idx_t;

  // per-component sign and prescaled magnitude
  typedef struct packed {
    logic [2:0]            neg;
    logic [2:0][MAG_W-1:0] mag;
  } lane_t;

  // cycles from an accepted word to its result strobe
  function automatic int prd_latency(int cb);
    return FRONT_STAGES + SQRT_STEPS + cb + 1;
  endfunction

  // round a Q.28 product to Q.16, half away from zero
  function automatic logic signed [T_W-1:0] rnd_shift(logic signed [PROD_W-1:0] p);
    logic [PROD_W-1:0] m;
    m = p[PROD_W-1] ? PROD_W'(-p) : PROD_W'(p);
    m = (m + PROD_W'(1 << (SIZE_FRAC - 1))) >> SIZE_FRAC;
    return p[PROD_W-1] ? -$signed(m[T_W-1:0]) : $signed(m[T_W-1:0]);
  endfunction

endpackage

// ===== hw/rtl/perspective_ray_direction.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// perspective_ray_direction
// Unit primary ray direction of a pinhole camera for one screen point.
//
//   channel   ports                                  handshake
//   input     in_point_x, in_point_y                 start, busy
//   result    out_dir_x, out_dir_y, out_dir_z         out_valid strobe
//   config    psel penable pwrite paddr pwdata        pready, prdata
//
// One word is taken every cycle while busy is low; each result passes through
// ten front stages, 32 square root stages, one divider stage per component
// bit and an output register.
// Reset is synchronous; busy stays high while reset is applied.
// The result strobe cannot be held off, so the pipeline never stalls.
// ----------------------------------------------------------------------------
module perspective_ray_direction #(
  parameter int COMPONENT_BITS = prd_pkg::CB_DEFAULT
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               start,
  output logic                               busy,
  input  logic [prd_pkg::COORD_W-1:0]        in_point_x,
  input  logic [prd_pkg::COORD_W-1:0]        in_point_y,
  output logic                               out_valid,
  output logic signed [COMPONENT_BITS-1:0]   out_dir_x,
  output logic signed [COMPONENT_BITS-1:0]   out_dir_y,
  output logic signed [COMPONENT_BITS-1:0]   out_dir_z,
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [prd_pkg::CFG_ADDR_W-1:0]     paddr,
  input  logic [prd_pkg::CFG_DATA_W-1:0]     pwdata,
  output logic [prd_pkg::CFG_DATA_W-1:0]     prdata,
  output logic                               pready
);
  import prd_pkg::*;

  localparam int CB     = COMPONENT_BITS;
  localparam int VREG_W = (3 * CB < VEC_REG_MAX) ? 3 * CB : VEC_REG_MAX;

  logic                    busy_r;
  logic [VREG_W-1:0]       view_r, up_r, horiz_r;
  logic [SIZE_W-1:0]       size_r;
  logic [3*CB+VREG_W-1:0]  view_ext, up_ext, horiz_ext;
  logic                    cfg_wr;
  reg_idx_t                cfg_idx;
  logic                    in_acc;
  logic                    f_vld, s_vld;
  logic [SUM_W-1:0]        f_sum;
  lane_t                   f_lane, s_lane;
  logic [ROOT_W-1:0]       s_root;
  logic signed [CB-1:0]    dir_w [3];

  // busy held through reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b1;
    end else begin
      busy_r <= 1'b0;
    end
  end

  assign busy   = busy_r;
  assign in_acc = start & ~busy_r;

  // configuration registers
  assign pready  = 1'b1;
  assign cfg_wr  = psel & penable & pwrite;
  assign cfg_idx = reg_idx_t'(paddr[CFG_ADDR_W-1:3]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      view_r  <= '0;
      up_r    <= '0;
      horiz_r <= '0;
      size_r  <= SIZE_W'(SIZE_RESET);
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        REG_VIEW:  view_r  <= pwdata[VREG_W-1:0];
        REG_UP:    up_r    <= pwdata[VREG_W-1:0];
        REG_HORIZ: horiz_r <= pwdata[VREG_W-1:0];
        REG_SIZE:  size_r  <= pwdata[SIZE_W-1:0];
        default:   size_r  <= size_r;
      endcase
    end
  end

  // read back
  always_comb begin
    unique case (cfg_idx)
      REG_VIEW:  prdata = CFG_DATA_W'(view_r);
      REG_UP:    prdata = CFG_DATA_W'(up_r);
      REG_HORIZ: prdata = CFG_DATA_W'(horiz_r);
      REG_SIZE:  prdata = CFG_DATA_W'(size_r);
      default:   prdata = '0;
    endcase
  end

  // components above the stored bits read as zero
  assign view_ext  = {{(3*CB){1'b0}}, view_r};
  assign up_ext    = {{(3*CB){1'b0}}, up_r};
  assign horiz_ext = {{(3*CB){1'b0}}, horiz_r};

  prd_front #(.COMPONENT_BITS(CB)) u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .valid_i     (in_acc),
    .point_x_i   (in_point_x),
    .point_y_i   (in_point_y),
    .view_vec_i  (view_ext[3*CB-1:0]),
    .up_vec_i    (up_ext[3*CB-1:0]),
    .horiz_vec_i (horiz_ext[3*CB-1:0]),
    .view_size_i (size_r),
    .valid_o     (f_vld),
    .sum_o       (f_sum),
    .lane_o      (f_lane)
  );

  prd_sqrt u_sqrt (
    .clk     (clk),
    .rst_n   (rst_n),
    .valid_i (f_vld),
    .sum_i   (f_sum),
    .lane_i  (f_lane),
    .valid_o (s_vld),
    .root_o  (s_root),
    .lane_o  (s_lane)
  );

  prd_div #(.COMPONENT_BITS(CB)) u_div (
    .clk     (clk),
    .rst_n   (rst_n),
    .valid_i (s_vld),
    .root_i  (s_root),
    .lane_i  (s_lane),
    .valid_o (out_valid),
    .dir_o   (dir_w)
  );

  assign out_dir_x = dir_w[0];
  assign out_dir_y = dir_w[1];
  assign out_dir_z = dir_w[2];

endmodule

// ===== hw/rtl/prd_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// prd_front
// Screen offsets, basis combination, magnitudes, prescale and sum of squares.
// Ten register stages.
// ----------------------------------------------------------------------------
module prd_front #(
  parameter int COMPONENT_BITS = prd_pkg::CB_DEFAULT
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               valid_i,
  input  logic [prd_pkg::COORD_W-1:0]        point_x_i,
  input  logic [prd_pkg::COORD_W-1:0]        point_y_i,
  input  logic [3*COMPONENT_BITS-1:0]        view_vec_i,
  input  logic [3*COMPONENT_BITS-1:0]        up_vec_i,
  input  logic [3*COMPONENT_BITS-1:0]        horiz_vec_i,
  input  logic [prd_pkg::SIZE_W-1:0]         view_size_i,
  output logic                               valid_o,
  output logic [prd_pkg::SUM_W-1:0]          sum_o,
  output prd_pkg::lane_t                     lane_o
);
  import prd_pkg::*;

  localparam int CB  = COMPONENT_BITS;
  localparam int V_W = CB + T_W + 2;
  localparam int K_W = $clog2(V_W - MAG_W + 1);

  logic [FRONT_STAGES-1:0]   vld_r;
  logic signed [DXY_W-1:0]   dx_r, dy_r;
  logic signed [PROD_W-1:0]  px_r, py_r;
  logic signed [T_W-1:0]     tx_r, ty_r;
  logic signed [V_W-1:0]     dt_r [3];
  logic signed [V_W-1:0]     ht_r [3];
  logic signed [V_W-1:0]     ut_r [3];
  logic [2:0]                neg5_r, neg6_r, neg7_r;
  logic [V_W-1:0]            mag5_r [3];
  logic [V_W-1:0]            mag6_r [3];
  logic [V_W-1:0]            mag7_r [3];
  logic [V_W-1:0]            or_r;
  logic [K_W-1:0]            k_r, k_nxt;
  lane_t                     ln8_r, ln9_r, ln10_r;
  logic [2*MAG_W-1:0]        sq_r [3];
  logic [SUM_W-1:0]          sum_r;

  // valid bits travel with the words
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= {vld_r[FRONT_STAGES-2:0], valid_i};
    end
  end

  // centered offsets, then scale by view size and round to Q.16
  always_ff @(posedge clk) begin
    dx_r <= $signed({1'b0, point_x_i}) - $signed(DXY_W'(HALF_COORD));
    dy_r <= $signed({1'b0, point_y_i}) - $signed(DXY_W'(HALF_COORD));
    px_r <= dx_r * $signed({1'b0, view_size_i});
    py_r <= dy_r * $signed({1'b0, view_size_i});
    tx_r <= rnd_shift(px_r);
    ty_r <= rnd_shift(py_r);
  end

  // per-component products and magnitudes
  for (genvar i = 0; i < 3; i++) begin : g_comp
    logic signed [CB-1:0]  dc, hc, uc;
    logic signed [V_W-1:0] v;
    assign dc = $signed(view_vec_i[i*CB +: CB]);
    assign hc = $signed(horiz_vec_i[i*CB +: CB]);
    assign uc = $signed(up_vec_i[i*CB +: CB]);
    assign v  = dt_r[i] + ht_r[i] + ut_r[i];

    always_ff @(posedge clk) begin
      dt_r[i]   <= {{(V_W-CB-16){dc[CB-1]}}, dc, 16'h0000};
      ht_r[i]   <= hc * tx_r;
      ut_r[i]   <= uc * ty_r;
      neg5_r[i] <= v[V_W-1];
      mag5_r[i] <= v[V_W-1] ? V_W'(-v) : V_W'(v);
      mag6_r[i] <= mag5_r[i];
      mag7_r[i] <= mag6_r[i];
    end
  end

  // shift count from the top set bit of the or of the magnitudes
  always_comb begin
    k_nxt = '0;
    for (int b = MAG_W; b < V_W; b++) begin
      if (or_r[b]) k_nxt = K_W'(b - MAG_W + 1);
    end
  end

  always_ff @(posedge clk) begin
    or_r   <= mag5_r[0] | mag5_r[1] | mag5_r[2];
    neg6_r <= neg5_r;
    k_r    <= k_nxt;
    neg7_r <= neg6_r;
  end

  // prescale, square, sum
  always_ff @(posedge clk) begin
    ln8_r.neg <= neg7_r;
    for (int i = 0; i < 3; i++) begin
      ln8_r.mag[i] <= MAG_W'(mag7_r[i] >> k_r);
      sq_r[i]      <= ln8_r.mag[i] * ln8_r.mag[i];
    end
    ln9_r  <= ln8_r;
    sum_r  <= SUM_W'(sq_r[0]) + SUM_W'(sq_r[1]) + SUM_W'(sq_r[2]);
    ln10_r <= ln9_r;
  end

  assign valid_o = vld_r[FRONT_STAGES-1];
  assign sum_o   = sum_r;
  assign lane_o  = ln10_r;

endmodule

// ===== hw/rtl/prd_sqrt.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// prd_sqrt
// Floor square root of the sum of squares, one root bit per register stage.
// ----------------------------------------------------------------------------
module prd_sqrt (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        valid_i,
  input  logic [prd_pkg::SUM_W-1:0]   sum_i,
  input  prd_pkg::lane_t              lane_i,
  output logic                        valid_o,
  output logic [prd_pkg::ROOT_W-1:0]  root_o,
  output prd_pkg::lane_t              lane_o
);
  import prd_pkg::*;

  logic [SQRT_STEPS-1:0] vld_r;
  logic [SQ_W-1:0]       s_r   [SQRT_STEPS];
  logic [SQ_W-1:0]       res_r [SQRT_STEPS];
  lane_t                 ln_r  [SQRT_STEPS];

  // valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= {vld_r[SQRT_STEPS-2:0], valid_i};
    end
  end

  // one trial subtract per stage
  for (genvar j = 0; j < SQRT_STEPS; j++) begin : g_step
    logic [SQ_W-1:0] s_in, res_in, bit_w, trial;
    lane_t           ln_in;
    if (j == 0) begin : g_first
      assign s_in   = SQ_W'(sum_i);
      assign res_in = '0;
      assign ln_in  = lane_i;
    end else begin : g_next
      assign s_in   = s_r[j-1];
      assign res_in = res_r[j-1];
      assign ln_in  = ln_r[j-1];
    end
    assign bit_w = SQ_W'(1) << (2 * (SQRT_STEPS - 1 - j));
    assign trial = res_in + bit_w;

    always_ff @(posedge clk) begin
      ln_r[j] <= ln_in;
      if (s_in >= trial) begin
        s_r[j]   <= s_in - trial;
        res_r[j] <= (res_in >> 1) + bit_w;
      end else begin
        s_r[j]   <= s_in;
        res_r[j] <= res_in >> 1;
      end
    end
  end

  assign valid_o = vld_r[SQRT_STEPS-1];
  assign root_o  = res_r[SQRT_STEPS-1][ROOT_W-1:0];
  assign lane_o  = ln_r[SQRT_STEPS-1];

endmodule

// ===== hw/rtl/prd_div.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// prd_div
// Three-lane restoring divider, magnitude over root, one quotient bit per
// stage, then rounding, saturation and sign.
// ----------------------------------------------------------------------------
module prd_div #(
  parameter int COMPONENT_BITS = prd_pkg::CB_DEFAULT
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             valid_i,
  input  logic [prd_pkg::ROOT_W-1:0]       root_i,
  input  prd_pkg::lane_t                   lane_i,
  output logic                             valid_o,
  output logic signed [COMPONENT_BITS-1:0] dir_o [3]
);
  import prd_pkg::*;

  localparam int CB    = COMPONENT_BITS;
  localparam int STEPS = CB;
  localparam int R_W   = ROOT_W + 1;
  localparam logic [CB-1:0] ONE = CB'(1) << (CB - 2);

  logic [STEPS-1:0]      vld_r;
  logic                  out_vld_r;
  logic [ROOT_W-1:0]     n_r   [STEPS];
  logic [2:0]            neg_r [STEPS];
  logic [R_W-1:0]        r_r   [STEPS][3];
  logic [CB-1:0]         q_r   [STEPS][3];
  logic signed [CB-1:0]  dir_r [3];

  // valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r     <= '0;
      out_vld_r <= 1'b0;
    end else begin
      vld_r     <= {vld_r[STEPS-2:0], valid_i};
      out_vld_r <= vld_r[STEPS-1];
    end
  end

  // quotient bit stages
  for (genvar j = 0; j < STEPS; j++) begin : g_step
    logic [ROOT_W-1:0] n_in;
    logic [2:0]        neg_in;
    if (j == 0) begin : g_first
      assign n_in   = root_i;
      assign neg_in = lane_i.neg;
    end else begin : g_next
      assign n_in   = n_r[j-1];
      assign neg_in = neg_r[j-1];
    end

    for (genvar l = 0; l < 3; l++) begin : g_lane
      logic [R_W-1:0] r_sh;
      logic [CB-1:0]  q_in;
      logic           qb;
      if (j == 0) begin : g_first
        assign r_sh = R_W'(lane_i.mag[l]);
        assign q_in = '0;
      end else begin : g_next
        assign r_sh = {r_r[j-1][l][R_W-2:0], 1'b0};
        assign q_in = q_r[j-1][l];
      end
      assign qb = (r_sh >= R_W'(n_in));

      always_ff @(posedge clk) begin
        r_r[j][l] <= qb ? r_sh - R_W'(n_in) : r_sh;
        q_r[j][l] <= {q_in[CB-2:0], qb};
      end
    end

    always_ff @(posedge clk) begin
      n_r[j]   <= n_in;
      neg_r[j] <= neg_in;
    end
  end

  // round half up from the extra quotient bit, saturate, apply sign
  for (genvar l = 0; l < 3; l++) begin : g_out
    logic [CB:0]   qp;
    logic [CB-1:0] qm;
    assign qp = {1'b0, q_r[STEPS-1][l]} + (CB+1)'(1);
    always_comb begin
      qm = qp[CB:1];
      if (qm > ONE) qm = ONE;
      if (n_r[STEPS-1] == '0) qm = '0;
    end
    always_ff @(posedge clk) begin
      dir_r[l] <= neg_r[STEPS-1][l] ? -$signed(qm) : $signed(qm);
    end
    assign dir_o[l] = dir_r[l];
  end

  assign valid_o = out_vld_r;

endmodule

// ===== hw/rtl/prd_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// prd_checker
// Port-level checks: fixed latency in both directions and unit-range output.
// ----------------------------------------------------------------------------
module prd_checker #(
  parameter int COMPONENT_BITS = prd_pkg::CB_DEFAULT
) (
  input logic                               clk,
  input logic                               rst_n,
  input logic                               start,
  input logic                               busy,
  input logic                               out_valid,
  input logic signed [COMPONENT_BITS-1:0]   out_dir_x,
  input logic signed [COMPONENT_BITS-1:0]   out_dir_y,
  input logic signed [COMPONENT_BITS-1:0]   out_dir_z
);
  import prd_pkg::*;

  localparam int LAT = prd_latency(COMPONENT_BITS);
  localparam int ONE = 1 << (COMPONENT_BITS - 2);

  logic acc;
  assign acc = start && !busy;

  // every accepted word yields a result after the fixed latency
  a_lat_hit: assert property (@(posedge clk) disable iff (!rst_n)
    acc |-> ##LAT out_valid)
    else $error("result strobe missing after accepted word");

  // no result without a word accepted the same latency earlier
  a_lat_none: assert property (@(posedge clk) disable iff (!rst_n)
    !acc |-> ##LAT !out_valid)
    else $error("result strobe without accepted word");

  // components never leave the unit range
  a_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ($signed(out_dir_x) <= ONE && $signed(out_dir_x) >= -ONE &&
                   $signed(out_dir_y) <= ONE && $signed(out_dir_y) >= -ONE &&
                   $signed(out_dir_z) <= ONE && $signed(out_dir_z) >= -ONE))
    else $error("direction component outside unit range");

endmodule

bind perspective_ray_direction prd_checker #(.COMPONENT_BITS(COMPONENT_BITS)) u_prd_chk (.*);

// ===== tb/sv/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Checks the pinhole camera ray direction block: a table of directed screen
// points, then random bursts, under several camera setups written over the
// register port. A local model of the fixed point math predicts every
// direction word and each strobe is compared with the oldest prediction.
// ----------------------------------------------------------------------------
module tb;
  import prd_pkg::*;

  localparam int CB   = 16;
  localparam int FB   = CB - 2;
  localparam int LAT  = 43 + CB;
  localparam int NRND = 950;

  typedef struct packed {
    logic signed [CB-1:0] dx;
    logic signed [CB-1:0] dy;
    logic signed [CB-1:0] dz;
  } ray_t;

  typedef struct {
    logic [COORD_W-1:0] px;
    logic [COORD_W-1:0] py;
    bit                 known;
    ray_t               ray;
  } point_row_t;

  logic clk = 0;
  logic rst_n = 0;
  logic start = 0;
  logic busy;
  logic [COORD_W-1:0] in_point_x = '0;
  logic [COORD_W-1:0] in_point_y = '0;
  logic out_valid;
  logic signed [CB-1:0] out_dir_x, out_dir_y, out_dir_z;
  logic psel = 0, penable = 0, pwrite = 0;
  logic [CFG_ADDR_W-1:0] paddr = '0;
  logic [CFG_DATA_W-1:0] pwdata = '0;
  logic [CFG_DATA_W-1:0] prdata;
  logic pready;

  // camera setup copy
  logic [3*CB-1:0] cam_view, cam_up, cam_horiz;
  logic [SIZE_W-1:0] cam_size;

  ray_t ray_q[$];
  int   err_cnt = 0;

  perspective_ray_direction #(.COMPONENT_BITS(CB)) DUT (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_point_x(in_point_x), .in_point_y(in_point_y),
    .out_valid(out_valid), .out_dir_x(out_dir_x), .out_dir_y(out_dir_y),
    .out_dir_z(out_dir_z), .psel(psel), .penable(penable), .pwrite(pwrite),
    .paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always #10 clk = ~clk;

  initial begin
    #50ms;
    $display("tb: errors");
    $finish;
  end

  task automatic report(input string what);
    $display("tb: mismatch %s at %0t", what, $realtime);
    err_cnt++;
  endtask

  // signed component i of a packed vector
  function automatic longint comp_of(logic [3*CB-1:0] r, int i);
    logic signed [CB-1:0] c;
    c = r[i*CB +: CB];
    return longint'(c);
  endfunction

  function automatic longint round_q12(longint p);
    longint m;
    m = p < 0 ? -p : p;
    m = (m + 2048) >>> 12;
    return p < 0 ? -m : m;
  endfunction

  function automatic longint unsigned floor_sqrt(longint unsigned s);
    longint unsigned res, b;
    res = 0;
    b = 64'd1 << 62;
    while (b > s) b >>= 2;
    while (b != 0) begin
      if (s >= res + b) begin
        s -= res + b;
        res = (res >> 1) + b;
      end else begin
        res >>= 1;
      end
      b >>= 2;
    end
    return res;
  endfunction

  // unit ray through one screen point
  function automatic ray_t ray_dir(logic [COORD_W-1:0] px, logic [COORD_W-1:0] py);
    longint tx, ty, v;
    longint unsigned mag[3], maxm, sum, n, q, one;
    bit neg[3];
    int k;
    logic signed [CB-1:0] o[3];
    tx = round_q12((longint'(px) - 32768) * longint'(cam_size));
    ty = round_q12((longint'(py) - 32768) * longint'(cam_size));
    maxm = 0;
    sum = 0;
    k = 0;
    one = 64'd1 << FB;
    for (int i = 0; i < 3; i++) begin
      v = comp_of(cam_view, i) * 65536 + comp_of(cam_horiz, i) * tx
        + comp_of(cam_up, i) * ty;
      neg[i] = v < 0;
      mag[i] = v < 0 ? -v : v;
      if (mag[i] > maxm) maxm = mag[i];
    end
    while ((maxm >> k) >= (64'd1 << 30)) k++;
    for (int i = 0; i < 3; i++) begin
      mag[i] >>= k;
      sum += mag[i] * mag[i];
    end
    n = floor_sqrt(sum);
    for (int i = 0; i < 3; i++) begin
      q = 0;
      if (n != 0) begin
        q = ((mag[i] << FB) + (n >> 1)) / n;
        if (q > one) q = one;
      end
      o[i] = neg[i] ? -CB'(q) : CB'(q);
    end
    return '{o[0], o[1], o[2]};
  endfunction

  // result checker
  always @(posedge clk) begin
    ray_t exp_r;
    if (rst_n && out_valid) begin
      if (ray_q.size() == 0) begin
        report("word with nothing pending");
      end else begin
        exp_r = ray_q.pop_front();
        if (out_dir_x !== exp_r.dx) report($sformatf("dir_x %0d/%0d", out_dir_x, exp_r.dx));
        if (out_dir_y !== exp_r.dy) report($sformatf("dir_y %0d/%0d", out_dir_y, exp_r.dy));
        if (out_dir_z !== exp_r.dz) report($sformatf("dir_z %0d/%0d", out_dir_z, exp_r.dz));
      end
    end
  end

  task automatic reg_write(reg_idx_t idx, logic [CFG_DATA_W-1:0] val);
    psel    <= 1;
    penable <= 0;
    pwrite  <= 1;
    paddr   <= CFG_ADDR_W'(8 * int'(idx));
    pwdata  <= val;
    @(posedge clk);
    penable <= 1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel    <= 0;
    penable <= 0;
    pwrite  <= 0;
    case (idx)
      REG_VIEW:  cam_view  = val[3*CB-1:0];
      REG_UP:    cam_up    = val[3*CB-1:0];
      REG_HORIZ: cam_horiz = val[3*CB-1:0];
      REG_SIZE:  cam_size  = val[SIZE_W-1:0];
      default: ;
    endcase
    // idle gap between transfers
    @(posedge clk);
  endtask

  function automatic logic [3*CB-1:0] pack3(int x, int y, int z);
    return {CB'(z), CB'(y), CB'(x)};
  endfunction

  task automatic set_camera(logic [3*CB-1:0] v, logic [3*CB-1:0] u,
                            logic [3*CB-1:0] h, logic [SIZE_W-1:0] s);
    reg_write(REG_VIEW, 64'(v));
    reg_write(REG_UP, 64'(u));
    reg_write(REG_HORIZ, 64'(h));
    reg_write(REG_SIZE, 64'(s));
  endtask

  // send one word, keep start high across back to back words
  task automatic send_point(logic [COORD_W-1:0] px, logic [COORD_W-1:0] py,
                            bit last_in_burst);
    start      <= 1;
    in_point_x <= px;
    in_point_y <= py;
    @(posedge clk);
    while (busy) @(posedge clk);
    ray_q.push_back(ray_dir(px, py));
    if (last_in_burst) begin
      start <= 0;
      @(posedge clk);
    end
  endtask

  task automatic drain;
    int guard;
    guard = 0;
    while (ray_q.size() != 0 && guard < 100000) begin
      @(posedge clk);
      guard++;
    end
    repeat (LAT + 4) @(posedge clk);
  endtask

  task automatic random_bursts(int cnt);
    int left, blen;
    logic [COORD_W-1:0] px, py;
    left = cnt;
    while (left > 0) begin
      blen = $urandom_range(1, 16);
      if (blen > left) blen = left;
      for (int b = 0; b < blen; b++) begin
        case ($urandom_range(0, 9))
          0: px = COORD_W'($urandom_range(0, 131071));
          1: px = $urandom_range(0, 1) ? 17'd0 : 17'd65536;
          default: px = COORD_W'($urandom_range(0, 65536));
        endcase
        case ($urandom_range(0, 9))
          0: py = COORD_W'($urandom_range(0, 131071));
          1: py = $urandom_range(0, 1) ? 17'd0 : 17'd65536;
          default: py = COORD_W'($urandom_range(0, 65536));
        endcase
        send_point(px, py, b == blen - 1);
      end
      left -= blen;
      if ($urandom_range(0, 2) != 0) repeat ($urandom_range(1, 12)) @(posedge clk);
    end
  endtask

  function automatic logic [3*CB-1:0] rand_vec();
    return {16'($urandom), 16'($urandom), 16'($urandom)};
  endfunction

  point_row_t point_tab[$];

  initial begin
    ray_t zero_r;
    zero_r = '0;
    cam_view = '0;
    cam_up = '0;
    cam_horiz = '0;
    cam_size = SIZE_W'(SIZE_RESET);
    repeat (9) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    // reset camera: every vector zero, so every ray is zero
    point_tab = '{
      '{17'd32768, 17'd32768, 1, zero_r},
      '{17'd0,     17'd65536, 1, zero_r},
      '{17'h1FFFF, 17'h1FFFF, 1, zero_r}
    };
    foreach (point_tab[i]) begin
      send_point(point_tab[i].px, point_tab[i].py, 1);
      if (point_tab[i].known && ray_q[$] !== point_tab[i].ray) report("reset row model");
    end
    drain();

    // straight camera: center point looks down +z
    set_camera(pack3(0, 0, 16384), pack3(0, 16384, 0), pack3(16384, 0, 0),
               SIZE_W'(SIZE_RESET));
    point_tab = '{
      '{17'd32768, 17'd32768, 1, '{16'sd0, 16'sd0, 16'sd16384}},
      '{17'd0,     17'd0,     0, zero_r},
      '{17'd65536, 17'd65536, 0, zero_r},
      '{17'd0,     17'd65536, 0, zero_r},
      '{17'd65536, 17'd0,     0, zero_r},
      '{17'h1FFFF, 17'd0,     0, zero_r},
      '{17'd12345, 17'h1FFFF, 0, zero_r},
      '{17'h15555, 17'h0AAAA, 0, zero_r},
      '{17'h0AAAA, 17'h15555, 0, zero_r}
    };
    foreach (point_tab[i]) begin
      send_point(point_tab[i].px, point_tab[i].py, i == point_tab.size() - 1);
      if (point_tab[i].known && ray_q[$] !== point_tab[i].ray) report("table row model");
    end
    drain();

    // extreme components and view sizes, plus a view vector canceling the offsets
    set_camera(pack3(-32768, 32767, -32768), pack3(32767, -32768, 32767),
               pack3(-32768, -32768, 32767), 16'hFFFF);
    send_point(17'd0, 17'h1FFFF, 0);
    send_point(17'h1FFFF, 17'd0, 0);
    send_point(17'd32768, 17'd32768, 1);
    drain();
    set_camera(pack3(16384, 0, 0), pack3(0, 0, 0), pack3(16384, 0, 0), 16'd8192);
    send_point(17'd0, 17'd0, 0);
    send_point(17'd32768, 17'd0, 1);
    drain();
    set_camera(pack3(0, 0, 16384), pack3(0, 16384, 0), pack3(16384, 0, 0), 16'd0);
    random_bursts(10);
    drain();

    // random cameras, and fixed cameras with random view sizes
    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0: set_camera(rand_vec(), rand_vec(), rand_vec(), 16'hFFFF);
        1: set_camera(pack3(0, 0, 16384), pack3(0, 16384, 0), pack3(16384, 0, 0),
                      16'($urandom_range(1024, 16384)));
        2: set_camera(pack3(11585, 0, 11585), pack3(0, 16384, 0),
                      pack3(11585, 0, -11585), 16'($urandom_range(0, 65535)));
        default: set_camera(rand_vec(), rand_vec(), rand_vec(),
                            16'($urandom_range(0, 65535)));
      endcase
      random_bursts(NRND / 6);
      drain();
    end

    if (err_cnt == 0) begin
      $display("tb: clean");
    end else begin
      $display("tb: errors");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
hw/rtl/prd_pkg.sv
hw/rtl/prd_front.sv
hw/rtl/prd_sqrt.sv
hw/rtl/prd_div.sv
hw/rtl/perspective_ray_direction.sv
hw/rtl/prd_checker.sv
tb/sv/tb.sv
